@@ rtl/hrmp_pkg.sv @@
// shared types, constants and helpers for the heading-rate motion predictor
// no dependencies; used by hrmp_cordic and heading_rate_motion_predict
package hrmp_pkg;

	// default and limit of the cordic depth
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 30;

	// internal cordic datapath width (q1.30 plus growth headroom)
	localparam int CW = 34;

	// dt after reset, unsigned q0.16 seconds
	localparam logic [15:0] STEP_TIME_RST = 16'd655;

	// round(2^32 / (2*pi)): radians q16.16 to binary angle
	localparam logic [30:0] TURN_SCALE = 31'd683565276;

	// cordic gain compensation, q1.30
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef logic signed [31:0] q16_t;

	// one input item
	typedef struct packed {
		q16_t pos_x;
		q16_t pos_y;
		q16_t heading;
		q16_t speed;
		q16_t turn_rate;
		q16_t accel;
	} in_t;

	// one result item
	typedef struct packed {
		q16_t next_x;
		q16_t next_y;
		q16_t next_heading;
		q16_t next_speed;
		q16_t next_turn_rate;
		q16_t next_accel;
	} out_t;

	// fields carried alongside the cordic stages
	typedef struct packed {
		q16_t       pos_x;
		q16_t       pos_y;
		q16_t       speed;
		q16_t       turn_rate;
		q16_t       accel;
		q16_t       next_heading;
		q16_t       next_speed;
		logic [1:0] quad;
	} side_t;

	// binary angle of atan(2^-idx), 2^32 per turn
	function automatic logic signed [CW-1:0] atan_turn(input int idx);
		logic signed [CW-1:0] a;
		case (idx)
			0:       a = 34'sd536870912;
			1:       a = 34'sd316933406;
			2:       a = 34'sd167458907;
			3:       a = 34'sd85004756;
			4:       a = 34'sd42667331;
			5:       a = 34'sd21354465;
			6:       a = 34'sd10679838;
			7:       a = 34'sd5340245;
			8:       a = 34'sd2670163;
			9:       a = 34'sd1335087;
			10:      a = 34'sd667544;
			11:      a = 34'sd333772;
			12:      a = 34'sd166886;
			13:      a = 34'sd83443;
			14:      a = 34'sd41722;
			15:      a = 34'sd20861;
			16:      a = 34'sd10430;
			17:      a = 34'sd5215;
			18:      a = 34'sd2608;
			19:      a = 34'sd1304;
			20:      a = 34'sd652;
			21:      a = 34'sd326;
			22:      a = 34'sd163;
			23:      a = 34'sd81;
			24:      a = 34'sd41;
			25:      a = 34'sd20;
			26:      a = 34'sd10;
			27:      a = 34'sd5;
			28:      a = 34'sd3;
			29:      a = 34'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// clamp to the signed 32-bit range
	function automatic q16_t sat32(input logic signed [35:0] v);
		q16_t r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/hrmp_cordic.sv @@
// pipelined rotation-mode cordic, one micro-rotation per register stage
// depends on hrmp_pkg; side fields ride along with each stage
module hrmp_cordic
	import hrmp_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic [STAGES-1:0]    en,
	input  logic signed [CW-1:0] z_in,
	input  side_t                side_in,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output side_t                side_out
);

	logic signed [CW-1:0] x_s [STAGES];
	logic signed [CW-1:0] y_s [STAGES];
	logic signed [CW-1:0] z_s [STAGES];
	side_t                side_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [CW-1:0] xp;
		logic signed [CW-1:0] yp;
		logic signed [CW-1:0] zp;
		side_t                sp;

		// stage inputs: seed values for the first stage
		if (i == 0) begin : g_first
			assign xp = CORDIC_GAIN;
			assign yp = '0;
			assign zp = z_in;
			assign sp = side_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign sp = side_s[i-1];
		end

		// micro-rotation toward zero residual angle
		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (!zp[CW-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - atan_turn(i);
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + atan_turn(i);
				end
				side_s[i] <= sp;
			end
		end
	end

	assign x_out    = x_s[STAGES-1];
	assign y_out    = y_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule

@@ rtl/heading_rate_motion_predict.sv @@
// top level of the constant turn-rate and acceleration one-step predictor
// depends on hrmp_pkg and hrmp_cordic
//
// Takes one six-field Q16.16 motion state per transfer and returns the state one
// interval dt later, dt being the step_time register (unsigned Q0.16 s, reset 655).
// Position moves along the heading by speed*dt, heading by turn_rate*dt (never
// wrapped), speed by accel*dt; every sum saturates to 32 bits. The datapath is a
// fully pipelined chain of CORDIC_STAGES+6 registers, and a new item is taken
// every cycle while in_stall is low. The chain is the CORDIC depth, one
// micro-rotation per stage, plus angle reduction, quadrant fold, quadrant
// map-back, two multiplier stages and the saturating add. Each stage holds its
// item under a downstream stall and fills empty slots, so in_stall only rises
// when every stage is occupied and out_stall is high. step_time should only be
// written while the pipeline is empty.
module heading_rate_motion_predict
	import hrmp_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	localparam int L      = CORDIC_STAGES + 6;
	localparam int ST_MAP = CORDIC_STAGES + 2;
	localparam int ST_MUL = CORDIC_STAGES + 3;
	localparam int ST_DT  = CORDIC_STAGES + 4;
	localparam int ST_OUT = CORDIC_STAGES + 5;

	logic [15:0] step_time_q;
	logic [L-1:0] vld_q;
	logic [L:0]   rdy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= STEP_TIME_RST;
		end else if (cfg_wen) begin
			step_time_q <= cfg_wdata;
		end
	end

	// per-stage ready: a stage may load when empty or when its item moves on
	always_comb begin
		rdy[L] = !out_stall;
		for (int k = L - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[L-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < L; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	// stage 1: angle reduction and rate products
	logic signed [63:0] phase_prod;
	logic signed [48:0] hd_prod;
	logic signed [48:0] sp_prod;

	assign phase_prod = $signed(in_data.heading) * $signed({1'b0, TURN_SCALE});
	assign hd_prod    = $signed(in_data.turn_rate) * $signed({1'b0, step_time_q});
	assign sp_prod    = $signed(in_data.accel) * $signed({1'b0, step_time_q});

	in_t                in_s1;
	logic [31:0]        phase_s1;
	logic signed [48:0] hd_prod_s1;
	logic signed [48:0] sp_prod_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			in_s1      <= in_data;
			phase_s1   <= phase_prod[47:16];
			hd_prod_s1 <= hd_prod;
			sp_prod_s1 <= sp_prod;
		end
	end

	// stage 2: quadrant fold, residual angle, heading and speed updates
	logic [31:0]        phase_rnd;
	logic [1:0]         quad;
	logic [31:0]        resid;
	logic signed [48:0] hd_rnd;
	logic signed [48:0] sp_rnd;
	logic signed [32:0] hd_delta;
	logic signed [32:0] sp_delta;
	logic signed [35:0] hd_sum;
	logic signed [35:0] sp_sum;

	assign phase_rnd = phase_s1 + 32'h2000_0000;
	assign quad      = phase_rnd[31:30];
	assign resid     = phase_s1 - {quad, 30'd0};
	assign hd_rnd    = hd_prod_s1 + 49'sd32768;
	assign sp_rnd    = sp_prod_s1 + 49'sd32768;
	assign hd_delta  = hd_rnd[48:16];
	assign sp_delta  = sp_rnd[48:16];
	assign hd_sum    = {{4{in_s1.heading[31]}}, in_s1.heading}
		+ {{3{hd_delta[32]}}, hd_delta};
	assign sp_sum    = {{4{in_s1.speed[31]}}, in_s1.speed}
		+ {{3{sp_delta[32]}}, sp_delta};

	logic signed [CW-1:0] z_s2;
	side_t                side_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			z_s2                 <= {{(CW-32){resid[31]}}, resid};
			side_s2.pos_x        <= in_s1.pos_x;
			side_s2.pos_y        <= in_s1.pos_y;
			side_s2.speed        <= in_s1.speed;
			side_s2.turn_rate    <= in_s1.turn_rate;
			side_s2.accel        <= in_s1.accel;
			side_s2.next_heading <= sat32(hd_sum);
			side_s2.next_speed   <= sat32(sp_sum);
			side_s2.quad         <= quad;
		end
	end

	// cordic stages
	logic signed [CW-1:0] cx;
	logic signed [CW-1:0] cy;
	side_t                side_c;

	hrmp_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.en       (rdy[ST_MAP-1:2]),
		.z_in     (z_s2),
		.side_in  (side_s2),
		.x_out    (cx),
		.y_out    (cy),
		.side_out (side_c)
	);

	// stage 3 (after cordic): map rotation result back to its quadrant
	logic signed [CW-1:0] cos_s3;
	logic signed [CW-1:0] sin_s3;
	side_t                side_s3;

	always_ff @(posedge clk) begin
		if (rdy[ST_MAP]) begin
			case (side_c.quad)
				2'd0: begin
					cos_s3 <= cx;
					sin_s3 <= cy;
				end
				2'd1: begin
					cos_s3 <= -cy;
					sin_s3 <= cx;
				end
				2'd2: begin
					cos_s3 <= -cx;
					sin_s3 <= -cy;
				end
				default: begin
					cos_s3 <= cy;
					sin_s3 <= -cx;
				end
			endcase
			side_s3 <= side_c;
		end
	end

	// stage 4: speed times trig, scaled down by 2^15
	logic signed [65:0] vx_prod;
	logic signed [65:0] vy_prod;

	assign vx_prod = side_s3.speed * cos_s3;
	assign vy_prod = side_s3.speed * sin_s3;

	logic signed [47:0] tx_s4;
	logic signed [47:0] ty_s4;
	side_t              side_s4;

	always_ff @(posedge clk) begin
		if (rdy[ST_MUL]) begin
			tx_s4   <= vx_prod[62:15];
			ty_s4   <= vy_prod[62:15];
			side_s4 <= side_s3;
		end
	end

	// stage 5: times dt with round half up
	logic signed [64:0] dx_prod;
	logic signed [64:0] dy_prod;

	assign dx_prod = tx_s4 * $signed({1'b0, step_time_q}) + 65'sd1073741824;
	assign dy_prod = ty_s4 * $signed({1'b0, step_time_q}) + 65'sd1073741824;

	logic signed [33:0] dx_s5;
	logic signed [33:0] dy_s5;
	side_t              side_s5;

	always_ff @(posedge clk) begin
		if (rdy[ST_DT]) begin
			dx_s5   <= dx_prod[64:31];
			dy_s5   <= dy_prod[64:31];
			side_s5 <= side_s4;
		end
	end

	// stage 6: saturating position update into the output register
	logic signed [35:0] x_sum;
	logic signed [35:0] y_sum;

	assign x_sum = {{4{side_s5.pos_x[31]}}, side_s5.pos_x} + {{2{dx_s5[33]}}, dx_s5};
	assign y_sum = {{4{side_s5.pos_y[31]}}, side_s5.pos_y} + {{2{dy_s5[33]}}, dy_s5};

	out_t out_s6;

	always_ff @(posedge clk) begin
		if (rdy[ST_OUT]) begin
			out_s6.next_x         <= sat32(x_sum);
			out_s6.next_y         <= sat32(y_sum);
			out_s6.next_heading   <= side_s5.next_heading;
			out_s6.next_speed     <= side_s5.next_speed;
			out_s6.next_turn_rate <= side_s5.turn_rate;
			out_s6.next_accel     <= side_s5.accel;
		end
	end

	assign out_data = out_s6;

	// a stall at the input only comes from an occupied front stage
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_q[0])
		else $error("input stalled with empty front stage");

	// with the output free, nothing holds the input back
	a_no_stall_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// a full pipeline under output stall must stall the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(vld_q) == L) && out_stall |-> in_stall)
		else $error("full pipeline took a transfer");

	// an accepted transfer occupies the first stage
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted transfer lost at stage 1");

	// configuration write lands in the register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> step_time_q == $past(cfg_wdata))
		else $error("step_time write lost");

endmodule
